@@ rtl/tcp_option_scrubber_core_assert.svh @@
// assertion macros shared by the option scrubber rtl
`ifndef TCP_OPTION_SCRUBBER_CORE_ASSERT_SVH
`define TCP_OPTION_SCRUBBER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TOS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tos: assertion failed");
// next-cycle implication
`define TOS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tos: assertion failed");
`else
`define TOS_ASSERT_IMP(label, clk, rst, ante, cons)
`define TOS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/tos_pkg.sv @@
// shared types, constants and helpers of the tcp option scrubber
package tos_pkg;

  localparam int TOS_MAX_OPTION_BYTES = 40;
  localparam int TOS_RQ_DEPTH         = 4;
  localparam int TOS_CFG_INDEX_W      = 2;

  localparam logic [7:0] TOS_KIND_EOL      = 8'd0;
  localparam logic [7:0] TOS_KIND_NOP      = 8'd1;
  localparam logic [7:0] TOS_KIND_WSCALE   = 8'd3;
  localparam logic [7:0] TOS_KIND_SACKPERM = 8'd4;
  localparam logic [7:0] TOS_REPORT_KIND_RST = 8'd30;
  localparam logic [5:0] TOS_POS_MAX       = 6'd63;

  // configuration register indexes
  localparam logic [TOS_CFG_INDEX_W-1:0] TOS_REG_STRIP_SACK   = 2'd0;
  localparam logic [TOS_CFG_INDEX_W-1:0] TOS_REG_STRIP_WSCALE = 2'd1;
  localparam logic [TOS_CFG_INDEX_W-1:0] TOS_REG_REPORT_KIND  = 2'd2;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } tos_phase_t;

  typedef struct packed {
    logic       strip_sack_permitted;
    logic       strip_window_scale;
    logic [7:0] report_kind;
  } tos_cfg_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       first_of_area;
    logic [5:0] area_length;
    logic       last_of_area;
  } tos_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       kind_found;
    logic [5:0] kind_offset;
    logic [3:0] kind_subtype;
    logic       malformed;
  } tos_result_t;

  // up to two results per accepted byte, in order res_a then res_b
  typedef struct packed {
    logic [1:0]  count;
    tos_result_t res_a;
    tos_result_t res_b;
  } tos_push_t;

  // status fields only carry meaning on the last beat of an area
  function automatic tos_result_t tos_make_result(
    input logic [7:0] b,
    input logic       last,
    input logic       found,
    input logic [5:0] offset,
    input logic [3:0] subtype,
    input logic       bad
  );
    tos_result_t r;
    r.out_byte     = b;
    r.out_last     = last;
    r.kind_found   = last & found;
    r.kind_offset  = last ? offset : 6'd0;
    r.kind_subtype = last ? subtype : 4'd0;
    r.malformed    = last & bad;
    return r;
  endfunction

endpackage

@@ rtl/tos_in_if.sv @@
// input byte channel of the option scrubber
interface tos_in_if;
  import tos_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       first_of_area;
  logic [5:0] area_length;
  logic       last_of_area;

  modport source (output valid, output opt_byte, output first_of_area,
                  output area_length, output last_of_area, input ready);
  modport sink   (input valid, input opt_byte, input first_of_area,
                  input area_length, input last_of_area, output ready);
endinterface

@@ rtl/tos_out_if.sv @@
// result byte channel of the option scrubber
interface tos_out_if;
  import tos_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       kind_found;
  logic [5:0] kind_offset;
  logic [3:0] kind_subtype;
  logic       malformed;

  modport source (output valid, output out_byte, output out_last, output kind_found,
                  output kind_offset, output kind_subtype, output malformed,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input kind_found,
                  input kind_offset, input kind_subtype, input malformed,
                  output ready);
endinterface

@@ rtl/tos_cfg_if.sv @@
// configuration write channel of the option scrubber
interface tos_cfg_if;
  import tos_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TOS_CFG_INDEX_W-1:0] reg_index;
  logic [7:0]                 wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/tcp_option_scrubber_core.sv @@
// top level of the tcp option scrubber: config registers, parser and result queue
//
// tcp option scrubber: takes the options area one byte per beat and passes
// every byte on one beat later, with the first sack-permitted option and the
// first window-scale option overwritten by nop bytes when those strips are
// enabled. the last result beat of an area carries the offset and subtype
// nibble of the first option of report_kind and a malformed flag. the block
// takes one byte per cycle while opts_in.ready is high: the whole parse update
// for a byte is combinational logic on the area state registers,
// and its results land in a four-entry result queue. a byte normally yields
// one result beat; the last byte of an area yields two (the held byte and
// itself), so a stream sustains one byte per cycle while opts_out takes a beat
// per cycle. opts_in.ready stays high while the queue has room for two results,
// so it depends only on queue occupancy and never combinationally on
// opts_out.ready. there is no clearing pass after reset. configuration writes
// are always accepted and should only be made while no area is in flight.
`include "tcp_option_scrubber_core_assert.svh"
module tcp_option_scrubber_core #(
  parameter int MAX_OPTION_BYTES = tos_pkg::TOS_MAX_OPTION_BYTES
) (
  input  logic     clk,
  input  logic     rst,
  tos_cfg_if.sink  cfg,
  tos_in_if.sink   opts_in,
  tos_out_if.source opts_out
);
  import tos_pkg::*;

  tos_cfg_t  cfg_regs;
  tos_item_t item;
  tos_push_t push;
  logic      accept;
  logic      q_space;

  // config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.strip_sack_permitted <= 1'b1;
      cfg_regs.strip_window_scale   <= 1'b1;
      cfg_regs.report_kind          <= TOS_REPORT_KIND_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        TOS_REG_STRIP_SACK:   cfg_regs.strip_sack_permitted <= cfg.wr_data[0];
        TOS_REG_STRIP_WSCALE: cfg_regs.strip_window_scale   <= cfg.wr_data[0];
        TOS_REG_REPORT_KIND:  cfg_regs.report_kind          <= cfg.wr_data;
        default: begin
          // writes to unused indexes are dropped
        end
      endcase
    end
  end

  // input beat handshake, gated by queue room
  assign opts_in.ready = q_space;
  assign accept        = opts_in.valid && opts_in.ready;

  assign item.opt_byte      = opts_in.opt_byte;
  assign item.first_of_area = opts_in.first_of_area;
  assign item.area_length   = opts_in.area_length;
  assign item.last_of_area  = opts_in.last_of_area;

  // combinational parse and rewrite of each accepted byte
  tos_parser #(
    .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg_regs),
    .push   (push)
  );

  // result queue decouples the output beat from the input beat
  tos_result_q u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (q_space),
    .q_out (opts_out)
  );

  // a pair of results in one push only comes with the last byte of an area
  `TOS_ASSERT_IMP(a_pair_on_last, clk, rst, push.count == 2'd2, accept && item.last_of_area)
  // nothing enters the queue without an accepted byte
  `TOS_ASSERT_IMP(a_push_needs_beat, clk, rst, push.count != 2'd0, accept)

endmodule

@@ rtl/tos_parser.sv @@
// option parse state and per-byte update, one byte per accepted beat
`include "tcp_option_scrubber_core_assert.svh"
module tos_parser #(
  parameter int MAX_OPTION_BYTES = tos_pkg::TOS_MAX_OPTION_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tos_pkg::tos_item_t item,
  input  tos_pkg::tos_cfg_t  cfg,
  output tos_pkg::tos_push_t push
);
  import tos_pkg::*;

  localparam int LW = $clog2(MAX_OPTION_BYTES + 1);

  typedef struct packed {
    logic [7:0]    held_byte;
    logic          held_valid;
    logic [LW-1:0] bytes_left;
    tos_phase_t    phase;
    logic [LW-1:0] body_left;
    logic [7:0]    current_kind;
    logic [LW-1:0] blank_left;
    logic          sack_done;
    logic          window_done;
    logic          found_flag;
    logic [5:0]    found_offset;
    logic [3:0]    found_subtype;
    logic          bad_flag;
    logic [5:0]    position;
    logic          subtype_wait;
  } area_t;

  area_t       area;
  area_t       area_next;
  logic        ps, pw, pr;
  logic        kmatch, ms, mw, mr;
  logic [7:0]  b;
  logic [LW:0] rem;
  tos_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      area <= '0;
    end else begin
      area <= area_next;
    end
  end

  always_comb begin
    area_next = area;
    push      = '0;
    ps        = 1'b0;
    pw        = 1'b0;
    pr        = 1'b0;
    kmatch    = 1'b0;
    ms        = 1'b0;
    mw        = 1'b0;
    mr        = 1'b0;
    b         = item.opt_byte;
    rem       = '0;
    res       = '0;
    if (accept) begin
      // new area: flush the open one's held byte first
      if (item.first_of_area) begin
        if (area_next.held_valid) begin
          push.res_a = tos_make_result(area_next.held_byte, 1'b0, 1'b0, 6'd0, 4'd0, 1'b0);
          push.count = 2'd1;
        end
        area_next = '0;
        if (item.area_length > 6'(MAX_OPTION_BYTES)) begin
          area_next.bytes_left = LW'(MAX_OPTION_BYTES);
        end else begin
          area_next.bytes_left = LW'(item.area_length);
        end
      end

      ps = cfg.strip_sack_permitted && !area_next.sack_done;
      pw = cfg.strip_window_scale && !area_next.window_done;
      pr = !area_next.found_flag;

      unique case (area_next.phase)
        PH_KIND: begin
          kmatch = (ps && b == TOS_KIND_SACKPERM) || (pw && b == TOS_KIND_WSCALE) ||
                   (pr && b == cfg.report_kind);
          if (area_next.bytes_left == '0) begin
            area_next.phase = PH_DONE;
          end else if (kmatch || b > TOS_KIND_NOP) begin
            if (area_next.bytes_left < LW'(2)) begin
              // kind byte with no room for a length byte
              area_next.phase    = PH_DONE;
              area_next.bad_flag = area_next.bad_flag | ps | pw | pr;
            end else begin
              area_next.current_kind = b;
              area_next.phase        = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          rem = {1'b0, area_next.bytes_left} + (LW+1)'(1);
          ms  = ps && area_next.current_kind == TOS_KIND_SACKPERM;
          mw  = pw && area_next.current_kind == TOS_KIND_WSCALE;
          mr  = pr && area_next.current_kind == cfg.report_kind;
          if (b > 8'(rem)) begin
            area_next.phase    = PH_DONE;
            area_next.bad_flag = area_next.bad_flag | ps | pw | pr;
          end else begin
            if (ms) begin
              area_next.sack_done  = 1'b1;
              area_next.held_byte  = TOS_KIND_NOP;
              area_next.blank_left = LW'(1);
            end
            if (mw) begin
              area_next.window_done = 1'b1;
              if (b != 8'd0) begin
                area_next.held_byte  = TOS_KIND_NOP;
                area_next.blank_left = LW'(b - 8'd1);
              end
            end
            if (mr) begin
              area_next.found_flag    = 1'b1;
              area_next.found_offset  = area_next.position - 6'd1;
              area_next.found_subtype = 4'd0;
              area_next.subtype_wait  = (b >= 8'd3);
            end
            if (b < 8'd2) begin
              area_next.phase    = PH_DONE;
              area_next.bad_flag = area_next.bad_flag | (ps & !ms) | (pw & !mw) |
                                   (pr & !mr);
            end else begin
              area_next.body_left = LW'(b - 8'd2);
              area_next.phase     = (area_next.body_left != '0) ? PH_BODY : PH_KIND;
            end
          end
        end
        PH_BODY: begin
          if (area_next.subtype_wait) begin
            area_next.found_subtype = b[7:4];
            area_next.subtype_wait  = 1'b0;
          end
          if (area_next.body_left != '0) begin
            area_next.body_left = area_next.body_left - LW'(1);
          end
          if (area_next.body_left == '0) begin
            area_next.phase = PH_KIND;
          end
        end
        PH_DONE: begin
        end
      endcase

      // previous byte leaves, possibly already blanked by the length byte
      if (area_next.held_valid) begin
        push.res_a = tos_make_result(area_next.held_byte, 1'b0, 1'b0, 6'd0, 4'd0, 1'b0);
        push.count = 2'd1;
      end
      if (area_next.blank_left != '0) begin
        b                    = TOS_KIND_NOP;
        area_next.blank_left = area_next.blank_left - LW'(1);
      end
      area_next.held_byte  = b;
      area_next.held_valid = 1'b1;
      if (area_next.bytes_left != '0) begin
        area_next.bytes_left = area_next.bytes_left - LW'(1);
      end
      if (area_next.position != TOS_POS_MAX) begin
        area_next.position = area_next.position + 6'd1;
      end

      // last byte goes out together with the held one
      if (item.last_of_area) begin
        res = tos_make_result(b, 1'b1, area_next.found_flag, area_next.found_offset,
                              area_next.found_subtype, area_next.bad_flag);
        if (push.count == 2'd0) begin
          push.res_a = res;
        end else begin
          push.res_b = res;
        end
        push.count = push.count + 2'd1;
        area_next  = '0;
      end
    end
  end

  `TOS_ASSERT_IMP(a_empty_at_start, clk, rst, !area.held_valid, area.position == 6'd0)
  `TOS_ASSERT_NXT(a_last_closes, clk, rst, accept && item.last_of_area, !area.held_valid)

endmodule

@@ rtl/tos_result_q.sv @@
// small result queue between the parser and the output channel
`include "tcp_option_scrubber_core_assert.svh"
module tos_result_q (
  input  logic               clk,
  input  logic               rst,
  input  tos_pkg::tos_push_t push,
  output logic               space,
  tos_out_if.source          q_out
);
  import tos_pkg::*;

  localparam int PtrW = $clog2(TOS_RQ_DEPTH);
  localparam int CntW = $clog2(TOS_RQ_DEPTH + 1);

  tos_result_t     slots [TOS_RQ_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;
  tos_result_t     head;

  assign pop   = q_out.valid && q_out.ready;
  // room for the two results a single byte can produce
  assign space = count <= CntW'(TOS_RQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CntW'(push.count) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.res_a;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + PtrW'(1)] <= push.res_b;
    end
  end

  assign head               = slots[rd_ptr];
  assign q_out.valid        = count != '0;
  assign q_out.out_byte     = head.out_byte;
  assign q_out.out_last     = head.out_last;
  assign q_out.kind_found   = head.kind_found;
  assign q_out.kind_offset  = head.kind_offset;
  assign q_out.kind_subtype = head.kind_subtype;
  assign q_out.malformed    = head.malformed;

  `TOS_ASSERT_IMP(a_push_fits, clk, rst, push.count != 2'd0, space)

endmodule

@@ bench/option_stream_checker.sv @@
`timescale 1ns / 1ps
// option scrubber scoreboard: predicts every result beat from the input beats and compares them
module option_stream_checker (
  input  logic clk,
  input  logic rst,
  tos_cfg_if   cfg_ch,
  tos_in_if    in_ch,
  tos_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   beats_checked,
  output int   areas_closed,
  output int   reports_found,
  output int   malformed_areas
);
  import tos_pkg::*;

  localparam int MAX_SHOWN = 10;

  // register copies
  tos_cfg_t    regs;

  // area state of the predictor
  tos_phase_t  phase;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [5:0]  bytes_left;
  logic [7:0]  body_left;
  logic [7:0]  cur_kind;
  logic [7:0]  blank_left;
  logic        sack_done;
  logic        wscale_done;
  logic        rep_found;
  logic [5:0]  rep_offset;
  logic [3:0]  rep_subtype;
  logic        subtype_due;
  logic        len_error;
  logic [5:0]  pos;

  tos_result_t expected_beats[$];
  int          errors;
  int          shown;
  int          n_beats;
  int          n_areas;
  int          n_found;
  int          n_bad;

  task automatic clear_area_state();
    held_byte   = '0;
    held_valid  = 1'b0;
    bytes_left  = '0;
    phase       = PH_KIND;
    body_left   = '0;
    cur_kind    = '0;
    blank_left  = '0;
    sack_done   = 1'b0;
    wscale_done = 1'b0;
    rep_found   = 1'b0;
    rep_offset  = '0;
    rep_subtype = '0;
    subtype_due = 1'b0;
    len_error   = 1'b0;
    pos         = '0;
  endtask

  // status fields are zero except on the closing beat
  task automatic queue_beat(input logic [7:0] b, input logic last);
    tos_result_t r;
    r.out_byte     = b;
    r.out_last     = last;
    r.kind_found   = last && rep_found;
    r.kind_offset  = last ? rep_offset : 6'd0;
    r.kind_subtype = last ? rep_subtype : 4'd0;
    r.malformed    = last && len_error;
    expected_beats.push_back(r);
  endtask

  // one step of the kind / length / body walk over the original bytes
  task automatic scan_option_byte(input logic [7:0] b);
    logic want_sack, want_ws, want_rep, hit, is_sack, is_ws, is_rep;
    int   len, room;
    want_sack = regs.strip_sack_permitted && !sack_done;
    want_ws   = regs.strip_window_scale && !wscale_done;
    want_rep  = !rep_found;
    case (phase)
      PH_KIND: begin
        hit = (want_sack && b == TOS_KIND_SACKPERM) || (want_ws && b == TOS_KIND_WSCALE) ||
              (want_rep && b == regs.report_kind);
        if (bytes_left == 0) begin
          phase = PH_DONE;
        end else if (hit || b > TOS_KIND_NOP) begin
          if (bytes_left < 2) begin
            phase     = PH_DONE;
            len_error = len_error || want_sack || want_ws || want_rep;
          end else begin
            cur_kind = b;
            phase    = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        len     = b;
        room    = int'(bytes_left) + 1;
        is_sack = want_sack && cur_kind == TOS_KIND_SACKPERM;
        is_ws   = want_ws && cur_kind == TOS_KIND_WSCALE;
        is_rep  = want_rep && cur_kind == regs.report_kind;
        if (len > room) begin
          phase     = PH_DONE;
          len_error = len_error || want_sack || want_ws || want_rep;
        end else begin
          if (is_sack) begin
            sack_done  = 1'b1;
            held_byte  = TOS_KIND_NOP;
            blank_left = 8'd1;
          end
          if (is_ws) begin
            wscale_done = 1'b1;
            if (len >= 1) begin
              held_byte  = TOS_KIND_NOP;
              blank_left = 8'(len - 1);
            end
          end
          if (is_rep) begin
            rep_found   = 1'b1;
            rep_offset  = pos - 6'd1;
            rep_subtype = '0;
            subtype_due = (len >= 3);
          end
          if (len < 2) begin
            phase     = PH_DONE;
            len_error = len_error || (want_sack && !is_sack) || (want_ws && !is_ws) ||
                        (want_rep && !is_rep);
          end else begin
            body_left = 8'(len - 2);
            if (body_left != 0) phase = PH_BODY;
            else phase = PH_KIND;
          end
        end
      end
      PH_BODY: begin
        if (subtype_due) begin
          rep_subtype = b[7:4];
          subtype_due = 1'b0;
        end
        if (body_left > 0) body_left--;
        if (body_left == 0) phase = PH_KIND;
      end
      default: ;
    endcase
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic first, input logic [5:0] alen,
                              input logic last);
    logic [7:0] passed;
    if (first) begin
      if (held_valid) queue_beat(held_byte, 1'b0);
      clear_area_state();
      if (alen > TOS_MAX_OPTION_BYTES) bytes_left = 6'(TOS_MAX_OPTION_BYTES);
      else bytes_left = alen;
    end
    scan_option_byte(b);
    if (held_valid) queue_beat(held_byte, 1'b0);
    passed = b;
    if (blank_left > 0) begin
      passed = TOS_KIND_NOP;
      blank_left--;
    end
    held_byte  = passed;
    held_valid = 1'b1;
    if (bytes_left > 0) bytes_left--;
    if (pos != TOS_POS_MAX) pos++;
    if (last) begin
      queue_beat(held_byte, 1'b1);
      clear_area_state();
    end
  endtask

  always @(posedge clk) begin
    tos_result_t got, want;
    logic        differs;
    if (rst) begin
      regs.strip_sack_permitted = 1'b1;
      regs.strip_window_scale   = 1'b1;
      regs.report_kind          = TOS_REPORT_KIND_RST;
      clear_area_state();
      expected_beats.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          TOS_REG_STRIP_SACK:   regs.strip_sack_permitted = cfg_ch.wr_data[0];
          TOS_REG_STRIP_WSCALE: regs.strip_window_scale = cfg_ch.wr_data[0];
          TOS_REG_REPORT_KIND:  regs.report_kind = cfg_ch.wr_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_beat(in_ch.opt_byte, in_ch.first_of_area, in_ch.area_length, in_ch.last_of_area);
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte     = out_ch.out_byte;
        got.out_last     = out_ch.out_last;
        got.kind_found   = out_ch.kind_found;
        got.kind_offset  = out_ch.kind_offset;
        got.kind_subtype = out_ch.kind_subtype;
        got.malformed    = out_ch.malformed;
        n_beats++;
        if (expected_beats.size() == 0) begin
          errors++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t checker: unexpected beat byte=%h last=%b", $realtime,
                     got.out_byte, got.out_last);
          end
        end else begin
          want    = expected_beats.pop_front();
          differs = (got.out_byte !== want.out_byte) || (got.out_last !== want.out_last) ||
                    (got.kind_found !== want.kind_found) ||
                    (got.kind_offset !== want.kind_offset) ||
                    (got.kind_subtype !== want.kind_subtype) ||
                    (got.malformed !== want.malformed);
          if (differs) begin
            errors++;
            if (shown < MAX_SHOWN) begin
              shown++;
              $display("%0t checker: mismatch exp byte=%h last=%b found=%b off=%0d sub=%h bad=%b",
                       $realtime, want.out_byte, want.out_last, want.kind_found,
                       want.kind_offset, want.kind_subtype, want.malformed);
              $display("%0t checker:          got byte=%h last=%b found=%b off=%0d sub=%h bad=%b",
                       $realtime, got.out_byte, got.out_last, got.kind_found,
                       got.kind_offset, got.kind_subtype, got.malformed);
            end
          end
          if (want.out_last) begin
            n_areas++;
            if (want.kind_found) n_found++;
            if (want.malformed) n_bad++;
          end
        end
      end
    end
    fail_count      <= errors;
    pending         <= expected_beats.size();
    beats_checked   <= n_beats;
    areas_closed    <= n_areas;
    reports_found   <= n_found;
    malformed_areas <= n_bad;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// top of the option scrubber bench: clock, reset, byte stimulus, receiver stalls and verdict
module tb;
  import tos_pkg::*;

  // pacing of the run
  localparam int HOLD_OFF_CYCLES = 120;  // long receiver stall that backs the block up
  localparam int SETTLE_CYCLES   = 16;   // quiet time before touching the registers
  localparam int STALL_LIMIT     = 2000; // cycles without any beat before giving up
  localparam int PHASE_BYTES     = 85;   // random bytes per register setting

  // option kinds used only by the stimulus
  localparam logic [7:0] KIND_MSS      = 8'd2;
  localparam logic [7:0] KIND_RESERVED = 8'd255;

  logic clk = 1'b0;
  logic rst;

  tos_cfg_if cfg_if ();
  tos_in_if  in_if ();
  tos_out_if out_if ();

  int fail_count;
  int pending;
  int beats_checked;
  int areas_closed;
  int reports_found;
  int malformed_areas;

  int         stall_cycles;
  int         burst_left;
  int         bytes_sent;
  int         hold_requests;
  int         holds_done;
  logic [7:0] cur_report_kind;
  logic [7:0] area_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tcp_option_scrubber_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .opts_in  (in_if),
    .opts_out (out_if)
  );

  option_stream_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_ch          (cfg_if),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .fail_count      (fail_count),
    .pending         (pending),
    .beats_checked   (beats_checked),
    .areas_closed    (areas_closed),
    .reports_found   (reports_found),
    .malformed_areas (malformed_areas)
  );

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one input beat; the sender runs in bursts with random gaps between them.
  // valid stays high on return so back-to-back beats need no extra edge
  task automatic send_byte(input logic [7:0] b, input logic first, input logic [5:0] alen,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.opt_byte      <= b;
    in_if.first_of_area <= first;
    in_if.area_length   <= alen;
    in_if.last_of_area  <= last;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  // send the bytes in area_q as one area; close=0 leaves it open so the
  // next area start has to flush the held byte
  task automatic send_area(input logic [5:0] alen, input bit close);
    for (int i = 0; i < area_q.size(); i++)
      send_byte(area_q[i], i == 0, alen, close && (i == area_q.size() - 1));
  endtask

  // stop offering and wait until every predicted beat has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    burst_left = 0;
  endtask

  // config writes keep valid up between registers and drop it at the end
  task automatic write_reg(input logic [TOS_CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_regs(input logic sack, input logic wscale, input logic [7:0] kind);
    write_reg(TOS_REG_STRIP_SACK, {7'd0, sack});
    write_reg(TOS_REG_STRIP_WSCALE, {7'd0, wscale});
    write_reg(TOS_REG_REPORT_KIND, kind);
    cfg_if.valid    <= 1'b0;
    cur_report_kind = kind;
  endtask

  // random options area: mostly well-formed options with random content,
  // mixed with bad lengths and raw noise; a few areas aim at 20 to 40 bytes
  task automatic build_area(output logic [5:0] alen);
    int target, len;
    area_q.delete();
    target = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
    while (area_q.size() < target) begin
      case ($urandom_range(0, 11))
        0: area_q.push_back(TOS_KIND_NOP);
        1: area_q.push_back(TOS_KIND_EOL);
        2: begin
          area_q.push_back(TOS_KIND_SACKPERM);
          area_q.push_back(8'd2);
        end
        3: begin
          area_q.push_back(TOS_KIND_WSCALE);
          area_q.push_back(8'd3);
          area_q.push_back(8'($urandom_range(0, 14)));
        end
        4, 5: begin
          // option of the reported kind, subtype in the third byte
          len = $urandom_range(2, 8);
          area_q.push_back(cur_report_kind);
          area_q.push_back(8'(len));
          for (int k = 2; k < len; k++) area_q.push_back(8'($urandom_range(0, 255)));
        end
        6: begin
          area_q.push_back(KIND_MSS);
          area_q.push_back(8'd4);
          area_q.push_back(8'($urandom_range(0, 255)));
          area_q.push_back(8'($urandom_range(0, 255)));
        end
        7: begin
          len = $urandom_range(2, 10);
          area_q.push_back(8'($urandom_range(5, 255)));
          area_q.push_back(8'(len));
          for (int k = 2; k < len; k++) area_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          // window scale with short or odd length, 0 and 1 included
          len = $urandom_range(0, 5);
          area_q.push_back(TOS_KIND_WSCALE);
          area_q.push_back(8'(len));
          for (int k = 2; k < len; k++) area_q.push_back(8'($urandom_range(0, 255)));
        end
        9: begin
          area_q.push_back(TOS_KIND_SACKPERM);
          area_q.push_back(8'($urandom_range(0, 4)));
        end
        10: area_q.push_back(8'($urandom_range(0, 255)));
        default: begin
          // reported kind with a wild length byte
          area_q.push_back(cur_report_kind);
          area_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // area length: usually the byte count, sometimes short, sometimes anything up to 63
    case ($urandom_range(0, 9))
      0: alen = 6'($urandom_range(0, 63));
      1: alen = (area_q.size() > 2) ? 6'(area_q.size() - $urandom_range(1, 2))
                                    : 6'(area_q.size());
      default: alen = (area_q.size() > 40) ? 6'd40 : 6'(area_q.size());
    endcase
  endtask

  task automatic run_random(input int budget, input bit with_hold);
    logic [5:0] alen;
    int         start;
    start = bytes_sent;
    // receiver goes quiet for a long stretch while the sender keeps offering
    if (with_hold) hold_requests++;
    while (bytes_sent - start < budget) begin
      // stray byte outside any area
      if ($urandom_range(0, 14) == 0)
        send_byte(8'($urandom_range(0, 255)), 1'b0, 6'($urandom_range(0, 63)), 1'b0);
      build_area(alen);
      send_area(alen, $urandom_range(0, 11) != 0);
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    // single nop area leaves the stream closed
    send_byte(TOS_KIND_NOP, 1'b1, 6'd1, 1'b1);
  endtask

  // registers only change with nothing in flight
  task automatic next_phase(input logic sack, input logic wscale, input logic [7:0] kind,
                            input bit with_hold);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    program_regs(sack, wscale, kind);
    run_random(PHASE_BYTES, with_hold);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: its own stall pattern plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin
    int mode, run_len;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        run_len = $urandom_range(4, 40);
        repeat (run_len) begin
          case (mode)
            0: out_if.ready <= 1'b1;                              // no stalls
            1: out_if.ready <= 1'($urandom_range(0, 1));
            2: out_if.ready <= ($urandom_range(0, 3) != 0);       // light stalls
            default: out_if.ready <= ($urandom_range(0, 3) == 0); // heavy stalls
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles in which no beat moves on any channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: no beat moved for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    in_if.valid         <= 1'b0;
    in_if.opt_byte      <= '0;
    in_if.first_of_area <= 1'b0;
    in_if.area_length   <= '0;
    in_if.last_of_area  <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.reg_index    <= TOS_REG_STRIP_SACK;
    cfg_if.wr_data      <= '0;
    stall_cycles        = 0;
    burst_left          = 0;
    bytes_sent          = 0;
    hold_requests       = 0;
    holds_done          = 0;
    cur_report_kind     = TOS_REPORT_KIND_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, with the register values from reset
    // sack-permitted and window scale blanked, report kind found with subtype 5
    area_q = {TOS_KIND_NOP, TOS_KIND_SACKPERM, 8'd2, TOS_KIND_WSCALE, 8'd3, 8'h0e,
              TOS_REPORT_KIND_RST, 8'd6, 8'h5f, 8'h11, 8'h22, 8'h33, TOS_KIND_EOL};
    send_area(6'd13, 1'b1);
    // length byte far beyond the area stops the parse
    area_q = {KIND_MSS, 8'hff, TOS_KIND_EOL, TOS_KIND_EOL};
    send_area(6'd4, 1'b1);
    // one-byte area whose kind byte has no room for a length
    area_q = {TOS_REPORT_KIND_RST};
    send_area(6'd1, 1'b1);
    // stray byte, then an area over 40 bytes long opening while it is held;
    // window scale of length 1 blanks only its kind byte
    send_byte(8'h80, 1'b0, 6'd0, 1'b0);
    area_q = {TOS_KIND_WSCALE, 8'd1, TOS_KIND_SACKPERM, 8'd2};
    send_area(6'd63, 1'b1);
    // bytes beyond the area length pass unchanged
    area_q = {TOS_KIND_SACKPERM, 8'd2, KIND_RESERVED, TOS_KIND_EOL};
    send_area(6'd2, 1'b1);

    // random part over several register settings, extremes included
    run_random(PHASE_BYTES, 1'b1);
    next_phase(1'b0, 1'b0, 8'd0, 1'b0);
    next_phase(1'b1, 1'b0, 8'd255, 1'b0);
    next_phase(1'b0, 1'b1, TOS_KIND_SACKPERM, 1'b1);
    next_phase(1'b1, 1'b1, TOS_KIND_WSCALE, 1'b0);
    next_phase(1'b0, 1'b0, TOS_KIND_NOP, 1'b0);
    next_phase(1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'b0);
    next_phase(1'b1, 1'b1, TOS_REPORT_KIND_RST, 1'b0);

    // drain and let any late beat show up
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: sent %0d option bytes, checked %0d result beats over %0d closed areas",
             bytes_sent, beats_checked, areas_closed);
    $display("tb: %0d areas reported the wanted kind, %0d were flagged malformed",
             reports_found, malformed_areas);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ tcp_option_scrubber_core.f @@
+incdir+rtl
rtl/tos_pkg.sv
rtl/tos_in_if.sv
rtl/tos_out_if.sv
rtl/tos_cfg_if.sv
rtl/tos_parser.sv
rtl/tos_result_q.sv
rtl/tcp_option_scrubber_core.sv
bench/option_stream_checker.sv
bench/tb.sv
